// ----- hdl/tgc_pkg.sv -----
package tgc_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [15:0] COLOR_HOT   = 16'hF800;
	localparam logic [15:0] COLOR_COLD  = 16'h001F;
	localparam logic [15:0] COLOR_WHITE = 16'hFFFF;

	localparam logic [FRAC_BITS-1:0] FRAC_HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);
	localparam logic [FRAC_BITS+1:0] FRAC_TWO  = (FRAC_BITS+2)'(1) << (FRAC_BITS + 1);

	localparam logic [5:0] MAX_RB = 6'd31;
	localparam logic [5:0] MAX_G  = 6'd63;

	typedef enum logic [2:0] {
		KIND_HOT,
		KIND_COLD,
		KIND_WHITE,
		KIND_LOWER,
		KIND_UPPER
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] num;
		logic [15:0] den;
	} item_t;

	typedef struct packed {
		logic  empty;
		item_t item;
	} qhead_t;

	// One restoring division step: {quotient bit, new remainder}.
	function automatic logic [16:0] div_step(input logic [15:0] rem, input logic [15:0] den);
		logic [16:0] sh;
		logic [16:0] diff;
		sh   = {rem, 1'b0};
		diff = sh - {1'b0, den};
		if (sh >= {1'b0, den})
			return {1'b1, diff[15:0]};
		else
			return {1'b0, sh[15:0]};
	endfunction

endpackage

// ----- hdl/tgc_front.sv -----
module tgc_front (
	input  logic signed [15:0] reading,
	input  logic signed [15:0] low_limit,
	input  logic signed [15:0] target_level,
	input  logic signed [15:0] high_limit,
	output tgc_pkg::item_t     item
);
	import tgc_pkg::*;

	logic signed [16:0] rd, lo, tg, hi;
	logic signed [16:0] num_lo, den_lo, num_hi, den_hi;

	assign rd = 17'(reading);
	assign lo = 17'(low_limit);
	assign tg = 17'(target_level);
	assign hi = 17'(high_limit);

	assign num_lo = rd - lo;
	assign den_lo = tg - lo;
	assign num_hi = rd - tg;
	assign den_hi = hi - tg;

	always_comb begin
		item.num  = num_hi[15:0];
		item.den  = den_hi[15:0];
		if (rd >= hi)
			item.kind = KIND_HOT;
		else if (rd <= lo)
			item.kind = KIND_COLD;
		else if (tg <= lo || hi <= tg)
			item.kind = KIND_WHITE;
		else if (rd < tg) begin
			item.kind = KIND_LOWER;
			item.num  = num_lo[15:0];
			item.den  = den_lo[15:0];
		end else
			item.kind = KIND_UPPER;
	end

endmodule

// ----- hdl/tgc_queue.sv -----
module tgc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tgc_pkg::item_t wr_item,
	output logic           full,
	input  logic           pop,
	output tgc_pkg::qhead_t head
);
	import tgc_pkg::*;

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push, do_pop;

	assign full       = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head.empty = (count_q == '0);
	assign head.item  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && !head.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_item;
	end

endmodule

// ----- hdl/tgc_back.sv -----
module tgc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  tgc_pkg::qhead_t head,
	output logic            q_pop,
	output logic [15:0]     color_rgb565,
	output logic            empty,
	input  logic            pop
);
	import tgc_pkg::*;

	localparam int LAST = FRAC_BITS;

	// divider pipeline: stage j holds j quotient bits
	kind_t                kind_s [1:LAST];
	logic [15:0]          rem_s  [1:LAST];
	logic [15:0]          den_s  [1:LAST];
	logic [FRAC_BITS-1:0] quo_s  [1:LAST];
	logic [LAST:1]        vld_s;

	logic [16:0] step [1:LAST];
	logic        ob_full, adv;

	assign adv   = !(vld_s[LAST] && ob_full);
	assign q_pop = adv && !head.empty;

	always_comb begin
		step[1] = div_step(head.item.num, head.item.den);
		for (int j = 2; j <= LAST; j++)
			step[j] = div_step(rem_s[j-1], den_s[j-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (adv)
			vld_s <= {vld_s[LAST-1:1], !head.empty};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s[1] <= head.item.kind;
			den_s[1]  <= head.item.den;
			rem_s[1]  <= step[1][15:0];
			quo_s[1]  <= {{(FRAC_BITS-1){1'b0}}, step[1][16]};
			for (int j = 2; j <= LAST; j++) begin
				kind_s[j] <= kind_s[j-1];
				den_s[j]  <= den_s[j-1];
				rem_s[j]  <= step[j][15:0];
				quo_s[j]  <= {quo_s[j-1][FRAC_BITS-2:0], step[j][16]};
			end
		end
	end

	// hue to rgb: one channel ramps, the others sit at full or zero
	logic [FRAC_BITS-1:0] frac;
	logic                 le_half;
	logic [FRAC_BITS:0]   dbl, ramp;
	logic [FRAC_BITS+1:0] mirror;
	logic [5:0]           chan_max, ch;
	logic [FRAC_BITS+6:0] prod;
	logic [15:0]          color;

	assign frac    = quo_s[LAST];
	assign le_half = (frac <= FRAC_HALF);
	assign dbl     = {frac, 1'b0};
	assign mirror  = FRAC_TWO - {1'b0, dbl};
	assign ramp    = le_half ? dbl : mirror[FRAC_BITS:0];

	always_comb begin
		chan_max = MAX_RB;
		if ((kind_s[LAST] == KIND_LOWER) == le_half)
			chan_max = MAX_G;
	end

	assign prod = (FRAC_BITS+7)'(ramp) * (FRAC_BITS+7)'(chan_max);
	assign ch   = prod[FRAC_BITS+5:FRAC_BITS];

	always_comb begin
		case (kind_s[LAST])
			KIND_HOT:   color = COLOR_HOT;
			KIND_COLD:  color = COLOR_COLD;
			KIND_WHITE: color = COLOR_WHITE;
			KIND_LOWER: begin
				if (le_half)
					color = {5'd0, ch, MAX_RB[4:0]};
				else
					color = {5'd0, MAX_G, ch[4:0]};
			end
			KIND_UPPER: begin
				if (le_half)
					color = {ch[4:0], MAX_G, 5'd0};
				else
					color = {MAX_RB[4:0], ch, 5'd0};
			end
			default:    color = COLOR_WHITE;
		endcase
	end

	// two-word output buffer
	logic [15:0] ob_q [2];
	logic        ob_wr_q, ob_rd_q;
	logic [1:0]  ob_cnt_q;
	logic        ob_push, ob_pop;

	assign ob_full      = (ob_cnt_q == 2'd2);
	assign empty        = (ob_cnt_q == 2'd0);
	assign color_rgb565 = ob_q[ob_rd_q];
	assign ob_push      = vld_s[LAST] && adv;
	assign ob_pop       = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_wr_q  <= 1'b0;
			ob_rd_q  <= 1'b0;
			ob_cnt_q <= 2'd0;
		end else begin
			if (ob_push)
				ob_wr_q <= !ob_wr_q;
			if (ob_pop)
				ob_rd_q <= !ob_rd_q;
			if (ob_push && !ob_pop)
				ob_cnt_q <= ob_cnt_q + 2'd1;
			else if (ob_pop && !ob_push)
				ob_cnt_q <= ob_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ob_push)
			ob_q[ob_wr_q] <= color;
	end

endmodule

// ----- hdl/temperature_gradient_color_core.sv -----
// Temperature reading to RGB565 color.
// Input side is a queue: drive reading, low_limit, target_level, high_limit
// and push; the word is taken on a clock edge with push high and full low.
// Output side is a queue: while empty is low, color_rgb565 shows the oldest
// color; pop high on a clock edge with empty low takes it.
// The front end classifies each word (hot, cold, bad limits, below or above
// target) and forms the division operands; a four-word queue decouples it
// from the back end. The back end is a restoring divider, one quotient bit
// per stage over 16 stages, followed by the hue-to-RGB scaling and a
// two-word output buffer.
// A word is registered in the queue, each divider stage and output buffer.
// Throughput: one word per cycle while the output buffer is not full.
// Reset clears both queues and all stage valid bits; no word is in flight.
// When the receiver stalls, the output buffer fills, the divider pipeline
// holds, the middle queue fills and then full rises; no word is lost.
module temperature_gradient_color_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [15:0] reading,
	input  logic signed [15:0] low_limit,
	input  logic signed [15:0] target_level,
	input  logic signed [15:0] high_limit,
	input  logic               push,
	output logic               full,
	output logic [15:0]        color_rgb565,
	output logic               empty,
	input  logic               pop
);
	import tgc_pkg::*;

	item_t  front_item;
	qhead_t head;
	logic   q_pop;

	tgc_front u_front (
		.reading      (reading),
		.low_limit    (low_limit),
		.target_level (target_level),
		.high_limit   (high_limit),
		.item         (front_item)
	);

	tgc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (front_item),
		.full    (full),
		.pop     (q_pop),
		.head    (head)
	);

	tgc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_pop        (q_pop),
		.color_rgb565 (color_rgb565),
		.empty        (empty),
		.pop          (pop)
	);

endmodule

// ----- verif/temperature_gradient_color_checker.sv -----
module temperature_gradient_color_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [15:0] reading,
	input  logic signed [15:0] low_limit,
	input  logic signed [15:0] target_level,
	input  logic signed [15:0] high_limit,
	input  logic               push,
	input  logic               full,
	input  logic [15:0]        color_rgb565,
	input  logic               empty,
	input  logic               pop,
	output int                 mismatches,
	output int                 colors_checked,
	output int                 colors_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import tgc_pkg::*;

	logic [15:0] expected_colors[$];
	logic [15:0] wanted;

	// Truncating scale of a Q.FRAC_BITS level to a channel maximum.
	function automatic longint scale_level(input longint level, input longint chan_max);
		return (level * chan_max) >> FRAC_BITS;
	endfunction

	function automatic logic [15:0] predict_color(input int rd, input int lo, input int tg,
			input int hi);
		longint num, den, frac, twice, one, half;
		logic [4:0] red, blue;
		logic [5:0] green;
		one  = longint'(1) << FRAC_BITS;
		half = one >> 1;
		if (rd >= hi)
			return COLOR_HOT;
		if (rd <= lo)
			return COLOR_COLD;
		if (tg <= lo || hi <= tg)
			return COLOR_WHITE;
		if (rd < tg) begin
			num = rd - lo;
			den = tg - lo;
		end else begin
			num = rd - tg;
			den = hi - tg;
		end
		frac  = (num << FRAC_BITS) / den;
		twice = frac << 1;
		if (rd < tg) begin
			// blue to green
			red = '0;
			if (frac <= half) begin
				green = 6'(scale_level(twice, MAX_G));
				blue  = 5'(scale_level(one, MAX_RB));
			end else begin
				green = 6'(scale_level(one, MAX_G));
				blue  = 5'(scale_level(2 * one - twice, MAX_RB));
			end
		end else begin
			// green to red
			blue = '0;
			if (frac <= half) begin
				red   = 5'(scale_level(twice, MAX_RB));
				green = 6'(scale_level(one, MAX_G));
			end else begin
				red   = 5'(scale_level(one, MAX_RB));
				green = 6'(scale_level(2 * one - twice, MAX_G));
			end
		end
		return {red, green, blue};
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			expected_colors.delete();
			mismatches     <= 0;
			colors_checked <= 0;
			colors_pending <= 0;
		end else begin
			if (pop && !empty) begin
				if (expected_colors.size() == 0) begin
					$error("color_rgb565: word popped with none expected, got %h", color_rgb565);
					mismatches <= mismatches + 1;
				end else begin
					wanted = expected_colors.pop_front();
					if (color_rgb565 !== wanted) begin
						$error("color_rgb565 mismatch: expected %h, actual %h", wanted, color_rgb565);
						mismatches <= mismatches + 1;
					end
					colors_checked <= colors_checked + 1;
				end
			end
			if (push && !full)
				expected_colors.push_back(predict_color(reading, low_limit, target_level,
					high_limit));
			colors_pending <= expected_colors.size();
		end
	end

endmodule

// ----- verif/temperature_gradient_color_core_tb.sv -----
module temperature_gradient_color_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_WORDS = 1300;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE_WAIT  = 40;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic signed [15:0] reading      = '0;
	logic signed [15:0] low_limit    = '0;
	logic signed [15:0] target_level = '0;
	logic signed [15:0] high_limit   = '0;
	logic               push         = 1'b0;
	logic               pop          = 1'b0;
	logic               full;
	logic               empty;
	logic [15:0]        color_rgb565;

	int mismatches;
	int colors_checked;
	int colors_pending;
	int cycle_count  = 0;
	int directed_cnt = 0;
	int random_cnt   = 0;
	bit calm         = 1'b0;

	temperature_gradient_color_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.reading      (reading),
		.low_limit    (low_limit),
		.target_level (target_level),
		.high_limit   (high_limit),
		.push         (push),
		.full         (full),
		.color_rgb565 (color_rgb565),
		.empty        (empty),
		.pop          (pop)
	);

	temperature_gradient_color_checker color_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.reading        (reading),
		.low_limit      (low_limit),
		.target_level   (target_level),
		.high_limit     (high_limit),
		.push           (push),
		.full           (full),
		.color_rgb565   (color_rgb565),
		.empty          (empty),
		.pop            (pop),
		.mismatches     (mismatches),
		.colors_checked (colors_checked),
		.colors_pending (colors_pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d colors still expected", cycle_count,
				colors_pending);
			$display("temperature_gradient_color_core_tb: FAIL");
			$finish;
		end
	end

	// Receiver: stall at random except in the calm stretch.
	always @(negedge clk) begin
		pop <= calm || ($urandom_range(99) >= 38);
	end

	function automatic int pick_level(input int lo, input int hi);
		return int'($urandom_range(hi + 32768, lo + 32768)) - 32768;
	endfunction

	task automatic send_word(input int rd, input int lo, input int tg, input int hi);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 38) begin
			push    <= 1'b0;
			reading <= 16'($urandom);
			@(negedge clk);
		end
		reading      <= 16'(rd);
		low_limit    <= 16'(lo);
		target_level <= 16'(tg);
		high_limit   <= 16'(hi);
		push         <= 1'b1;
		do
			@(posedge clk);
		while (full);
	endtask

	// Hold off the sender until every color has come back.
	task automatic drain_colors();
		@(negedge clk);
		push <= 1'b0;
		while (colors_pending != 0)
			@(negedge clk);
	endtask

	task automatic send_random_word();
		int mode, lo, tg, hi, rd;
		mode = $urandom_range(99);
		if (mode < 35) begin
			lo = pick_level(-32768, 32765);
			hi = pick_level(lo + 2, 32767);
			tg = pick_level(lo + 1, hi - 1);
			rd = pick_level(lo + 1, hi - 1);
		end else if (mode < 55) begin
			// narrow spans, coarse fractions
			lo = pick_level(-32768, 32727);
			tg = lo + $urandom_range(20, 1);
			hi = tg + $urandom_range(20, 1);
			rd = pick_level(lo + 1, hi - 1);
		end else if (mode < 70) begin
			lo = pick_level(-32768, -30000);
			tg = pick_level(-2000, 2000);
			hi = pick_level(30000, 32767);
			rd = pick_level(lo + 1, hi - 1);
		end else if (mode < 82) begin
			// land on or next to a limit or the target
			lo = pick_level(-32768, 32765);
			hi = pick_level(lo + 2, 32767);
			tg = pick_level(lo + 1, hi - 1);
			case ($urandom_range(6))
				0: rd = tg;
				1: rd = tg - 1;
				2: rd = tg + 1;
				3: rd = lo + 1;
				4: rd = hi - 1;
				5: rd = lo;
				default: rd = hi;
			endcase
		end else begin
			lo = int'($signed(16'($urandom)));
			tg = int'($signed(16'($urandom)));
			hi = int'($signed(16'($urandom)));
			rd = int'($signed(16'($urandom)));
		end
		send_word(rd, lo, tg, hi);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// hot, cold and their precedence
		send_word(32767, -32768, 0, 32767);
		send_word(-32768, -32768, 0, 32767);
		send_word(0, 100, 50, -100);
		send_word(-5, 10, 20, 30);
		send_word(-32768, -32768, -32768, -32768);
		send_word(32767, 32767, 32767, 32767);
		// bad limit sets
		send_word(5, 0, 0, 10);
		send_word(5, 0, 10, 10);
		send_word(5, 0, -10, 10);
		send_word(5, 0, 20, 10);
		// on target, exact halves, just past halves
		send_word(0, -16, 0, 16);
		send_word(1, 0, 2, 10);
		send_word(3, 0, 2, 4);
		send_word(2, 0, 3, 10);
		send_word(4, 0, 2, 5);
		// widest spans, both ends of the fraction
		send_word(-32767, -32768, 32766, 32767);
		send_word(32765, -32768, 32766, 32767);
		send_word(-32766, -32768, -32767, 32767);
		send_word(32766, -32768, -32767, 32767);
		send_word(-1, -2, 0, 1);
		send_word(21845, -21846, 0, 32767);
		send_word(-21846, -32768, 21845, 32767);
		directed_cnt = 22;
		drain_colors();

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			calm = (i >= 500 && i < 800);
			if (i == 1000)
				drain_colors();
			send_random_word();
			random_cnt++;
		end
		calm = 1'b0;
		@(negedge clk);
		push <= 1'b0;

		while (colors_pending != 0)
			@(negedge clk);
		repeat (SETTLE_WAIT) @(negedge clk);

		$display("sent %0d words (%0d directed, %0d random) with stalls on both sides;",
			directed_cnt + random_cnt, directed_cnt, random_cnt);
		$display("checked %0d colors over hot, cold, bad-limit and interpolated hues",
			colors_checked);
		if (mismatches == 0 && colors_pending == 0)
			$display("temperature_gradient_color_core_tb: PASS");
		else
			$display("temperature_gradient_color_core_tb: FAIL");
		$finish;
	end

endmodule
